// ----- src/wtmf_pkg.sv -----
// ----------------------------------------------------------------------------
// wtmf_pkg
// Shared widths and defaults for the windowed trimmed-mean filter.
// ----------------------------------------------------------------------------
`default_nettype none

package wtmf_pkg;

  // One range sample and one result are both a byte.
  localparam int unsigned SAMPLE_W = 8;
  localparam int unsigned SAMPLE_MAX = (1 << SAMPLE_W) - 1;

  // Default window depth: ten samples, eight kept after trimming.
  localparam int unsigned DEFAULT_WINDOW_SIZE = 10;

  typedef logic [SAMPLE_W-1:0] sample_t;

endpackage : wtmf_pkg

`default_nettype wire

// ----- src/windowed_trimmed_mean_filter.sv -----
// ----------------------------------------------------------------------------
// windowed_trimmed_mean_filter
// Sliding window of byte samples, outputs the mean of the window without its
// smallest and largest entry, truncated.
//
// Usage: range_sample_i is taken on in_valid_i && !in_stall_o. Every accepted
// beat yields exactly one trimmed_mean_o beat, taken on out_valid_o &&
// !out_stall_i, in order.
// Path: an accepted beat goes through the window register, then the result
// register; a stall can hold it in the window stage. Throughput: one beat
// per cycle unless the receiver stalls. The window shift and a running sum
// are updated on accept; the next cycle runs a min/max tree over the window
// and one reciprocal multiply for the divide by WINDOW_SIZE - 2.
// Reset: the window and running sum are cleared to zero, so the first
// outputs average in those zeros. Both stages come up empty.
// Stall: a held result stays in the output register; one more beat sits in
// the window stage, after which in_stall_o rises until the receiver moves.
// ----------------------------------------------------------------------------
`default_nettype none

module windowed_trimmed_mean_filter #(
  parameter int unsigned WINDOW_SIZE = wtmf_pkg::DEFAULT_WINDOW_SIZE
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [wtmf_pkg::SAMPLE_W-1:0] range_sample_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [wtmf_pkg::SAMPLE_W-1:0]      trimmed_mean_o
);

  localparam int unsigned SW         = wtmf_pkg::SAMPLE_W;
  localparam int unsigned KEPT_COUNT = WINDOW_SIZE - 2;
  localparam int unsigned SUM_W      = $clog2(wtmf_pkg::SAMPLE_MAX * WINDOW_SIZE + 1);
  // Exact floor division by KEPT_COUNT for any dividend below 2**SUM_W.
  localparam int unsigned DIV_SHIFT  = SUM_W + $clog2(KEPT_COUNT);
  localparam int unsigned RECIP_W    = SUM_W + 1;
  localparam int unsigned RECIP      = ((1 << DIV_SHIFT) + KEPT_COUNT - 1) / KEPT_COUNT;
  localparam int unsigned PROD_W     = SUM_W + RECIP_W;
  localparam int unsigned TREE_LEAVES = 1 << $clog2(WINDOW_SIZE);
  localparam int unsigned TREE_NODES  = 2 * TREE_LEAVES - 1;

  localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);

  // Window stage
  wtmf_pkg::sample_t    window_q [WINDOW_SIZE];
  logic [SUM_W-1:0]     sum_q, sum_d;
  logic                 calc_valid_q;

  // Result stage
  logic                 out_valid_q;
  wtmf_pkg::sample_t    result_q;

  logic                 in_accept;
  logic                 out_load;

  wtmf_pkg::sample_t    min_node [TREE_NODES];
  wtmf_pkg::sample_t    max_node [TREE_NODES];
  logic [SUM_W-1:0]     kept_sum;
  logic [PROD_W-1:0]    prod;
  wtmf_pkg::sample_t    quotient;

  // ---- handshake ----
  assign out_load   = calc_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = calc_valid_q && !out_load;
  assign in_accept  = in_valid_i && !in_stall_o;

  // ---- window shift line and running sum ----
  assign sum_d = sum_q + SUM_W'(range_sample_i) - SUM_W'(window_q[WINDOW_SIZE-1]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW_SIZE; i++) begin
        window_q[i] <= '0;
      end
      sum_q <= '0;
    end else if (in_accept) begin
      window_q[0] <= range_sample_i;
      for (int i = 1; i < WINDOW_SIZE; i++) begin
        window_q[i] <= window_q[i-1];
      end
      sum_q <= sum_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      calc_valid_q <= 1'b0;
    end else if (in_accept) begin
      calc_valid_q <= 1'b1;
    end else if (out_load) begin
      calc_valid_q <= 1'b0;
    end
  end

  // ---- min / max tree, heap indexed, leaves padded with neutral values ----
  for (genvar l = 0; l < TREE_LEAVES; l++) begin : g_leaf
    if (l < WINDOW_SIZE) begin : g_used
      assign min_node[TREE_LEAVES-1+l] = window_q[l];
      assign max_node[TREE_LEAVES-1+l] = window_q[l];
    end else begin : g_pad
      assign min_node[TREE_LEAVES-1+l] = SW'(wtmf_pkg::SAMPLE_MAX);
      assign max_node[TREE_LEAVES-1+l] = '0;
    end
  end

  for (genvar n = 0; n < TREE_LEAVES - 1; n++) begin : g_node
    assign min_node[n] = (min_node[2*n+2] < min_node[2*n+1]) ? min_node[2*n+2]
                                                              : min_node[2*n+1];
    assign max_node[n] = (max_node[2*n+2] > max_node[2*n+1]) ? max_node[2*n+2]
                                                              : max_node[2*n+1];
  end

  // ---- trim and divide by reciprocal multiply ----
  assign kept_sum = sum_q - SUM_W'(min_node[0]) - SUM_W'(max_node[0]);
  assign prod     = PROD_W'(kept_sum) * PROD_W'(RECIP_C);
  assign quotient = prod[DIV_SHIFT +: SW];

  // ---- result register ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      result_q <= quotient;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign trimmed_mean_o = result_q;

  // ---- assertions ----
  a_stall_only_when_full : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (calc_valid_q && out_valid_q && out_stall_i)
  ) else $error("input stalled while a stage was free");

  a_accept_fills_window_stage : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> calc_valid_q
  ) else $error("accepted beat did not reach the window stage");

  a_result_from_window_stage : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(calc_valid_q)
  ) else $error("result appeared without a pending window beat");

  a_trim_bounds : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    calc_valid_q |-> (min_node[0] <= max_node[0] &&
                      SUM_W'(min_node[0]) + SUM_W'(max_node[0]) <= sum_q)
  ) else $error("running sum or min/max tree inconsistent");

endmodule : windowed_trimmed_mean_filter

`default_nettype wire

// ----- sim/tb_windowed_trimmed_mean_filter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_windowed_trimmed_mean_filter
// Self-checking bench for the trimmed-mean filter. A scoreboard class keeps
// its own ten-entry window, predicts the mean without min and max for every
// sample beat taken, and checks each result beat in order. Directed corner
// samples come first, then random phases with varied idling on both sides,
// a long output hold and pauses until all pending results have drained.
// ----------------------------------------------------------------------------

class trimmed_mean_tracker;
  localparam int unsigned WIN  = wtmf_pkg::DEFAULT_WINDOW_SIZE;
  localparam int unsigned KEEP = wtmf_pkg::DEFAULT_WINDOW_SIZE - 2;

  wtmf_pkg::sample_t window_samples[WIN];
  int unsigned       write_pos;
  wtmf_pkg::sample_t pending_means[$];
  int unsigned       mismatches;

  function new();
    foreach (window_samples[k]) window_samples[k] = '0;
    write_pos  = 0;
    mismatches = 0;
  endfunction

  // Accepted sample beat: slide the window and queue the expected mean.
  function void note_sample(wtmf_pkg::sample_t s);
    int unsigned total;
    int unsigned lo;
    int unsigned hi;
    window_samples[write_pos] = s;
    write_pos = (write_pos == WIN - 1) ? 0 : write_pos + 1;
    total = 0;
    lo    = wtmf_pkg::SAMPLE_MAX;
    hi    = 0;
    foreach (window_samples[k]) begin
      total += window_samples[k];
      if (window_samples[k] < lo) lo = window_samples[k];
      if (window_samples[k] > hi) hi = window_samples[k];
    end
    pending_means.push_back(wtmf_pkg::sample_t'((total - lo - hi) / KEEP));
  endfunction

  function void check_mean(wtmf_pkg::sample_t got);
    wtmf_pkg::sample_t want;
    if (pending_means.size() == 0) begin
      mismatches++;
      if (mismatches <= 40)
        $display("%0t: trimmed_mean expected none, actual %0d", $time, got);
      return;
    end
    want = pending_means.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 40)
        $display("%0t: trimmed_mean expected %0d, actual %0d", $time, want, got);
    end
  endfunction

  function int unsigned pending();
    return pending_means.size();
  endfunction
endclass

module tb_windowed_trimmed_mean_filter;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned LONG_HOLD   = 300;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  wtmf_pkg::sample_t range_sample;
  logic              out_valid;
  logic              out_stall;
  wtmf_pkg::sample_t trimmed_mean;

  trimmed_mean_tracker mean_board = new();

  bit          tx_idle_on;
  bit          rx_idle_on;
  int unsigned hold_request;
  int          drift_base;

  windowed_trimmed_mean_filter dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .range_sample_i (range_sample),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .trimmed_mean_o (trimmed_mean)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Entered and left at a falling edge.
  task automatic send_range(input wtmf_pkg::sample_t s);
    int unsigned gap;
    gap = tx_idle_on ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    range_sample <= s;
    do @(posedge clk); while (in_stall);
    mean_board.note_sample(s);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (mean_board.pending() != 0);
  endtask

  // Mix of sensor-like clusters, outlier spikes, full-range noise and extremes.
  function automatic wtmf_pkg::sample_t draw_range_sample();
    int v;
    int unsigned flavor;
    flavor = $urandom_range(0, 9);
    if ($urandom_range(0, 63) == 0) drift_base = $urandom_range(0, wtmf_pkg::SAMPLE_MAX);
    if (flavor <= 3) begin
      v = drift_base + $urandom_range(0, 8) - 4;
    end else if (flavor == 4) begin
      v = $urandom_range(0, 1) ? wtmf_pkg::SAMPLE_MAX : 0;
    end else if (flavor <= 7) begin
      v = $urandom_range(0, wtmf_pkg::SAMPLE_MAX);
    end else begin
      case ($urandom_range(0, 3))
        0:       v = 0;
        1:       v = 1;
        2:       v = wtmf_pkg::SAMPLE_MAX - 1;
        default: v = wtmf_pkg::SAMPLE_MAX;
      endcase
    end
    if (v < 0) v = 0;
    if (v > wtmf_pkg::SAMPLE_MAX) v = wtmf_pkg::SAMPLE_MAX;
    return wtmf_pkg::sample_t'(v);
  endfunction

  task automatic run_random(input int unsigned count);
    repeat (count) send_range(draw_range_sample());
  endtask

  // Receiver: one stall draw per result beat, or a long hold on request.
  initial begin
    int unsigned hold;
    out_stall = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (hold_request > 0) begin
        hold         = hold_request;
        hold_request = 0;
      end else begin
        hold = rx_idle_on ? $urandom_range(0, 17) : 0;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) mean_board.check_mean(trimmed_mean);
  end

  // Watchdog: too many cycles in a row with no beat on either side.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    wtmf_pkg::sample_t corner_samples[$];
    in_valid     = 1'b0;
    range_sample = '0;
    rst_n        = 1'b0;
    tx_idle_on   = 1'b1;
    rx_idle_on   = 1'b1;
    hold_request = 0;
    drift_base   = 128;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Early outputs mix reset zeros with full-scale samples until the
    // window is all 255; then walking ones, ties at zero and a small value.
    repeat (10) corner_samples.push_back(8'hFF);
    for (int b = 0; b < wtmf_pkg::SAMPLE_W; b++)
      corner_samples.push_back(wtmf_pkg::sample_t'(1 << b));
    corner_samples.push_back(8'h00);
    corner_samples.push_back(8'h00);
    corner_samples.push_back(8'hFF);
    corner_samples.push_back(8'h07);
    foreach (corner_samples[k]) send_range(corner_samples[k]);

    run_random(400);

    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    run_random(300);
    wait_drained();

    // Receiver sits on a result while the sender keeps offering beats.
    hold_request = LONG_HOLD;
    run_random(200);

    tx_idle_on = 1'b1;
    run_random(400);
    wait_drained();

    tx_idle_on = 1'b0;
    rx_idle_on = 1'b1;
    run_random(400);

    tx_idle_on = 1'b1;
    run_random(200);

    wait_drained();
    repeat (20) @(negedge clk);
    if (mean_board.mismatches == 0 && mean_board.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
